/* sv/phr_pkg.sv */
// ----------------------------------------------------------------------------
// phr_pkg
// Shared widths, command codes and control structs for the peak history block.
// ----------------------------------------------------------------------------
package phr_pkg;

  // field widths
  localparam int CMD_W  = 2;
  localparam int CH_W   = 3;
  localparam int PEAK_W = 32;
  localparam int POS_W  = 62;
  localparam int SPOS_W = 63;
  localparam int RIDX_W = 9;
  localparam int NIDX_W = 9;
  localparam int CFG_W  = 9;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_RESET  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd3;

  // index result when nothing matches
  localparam logic [NIDX_W-1:0] NONE_IDX = '1;

  // search sequencing toward the distance unit
  typedef struct packed {
    logic              start;
    logic              sample;
    logic [NIDX_W-1:0] idx;
  } srch_ctl_t;

  // distance unit status back to the sequencer
  typedef struct packed {
    logic              busy;
    logic [NIDX_W-1:0] best_idx;
  } srch_sts_t;

endpackage

/* sv/phr_if.sv */
// ----------------------------------------------------------------------------
// phr_in_if / phr_out_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface phr_in_if;
  logic                                valid;
  logic                                ready;
  logic        [phr_pkg::CMD_W-1:0]    command;
  logic        [phr_pkg::CH_W-1:0]     channel;
  logic signed [phr_pkg::PEAK_W-1:0]   peak_level;
  logic        [phr_pkg::POS_W-1:0]    position;
  logic signed [phr_pkg::RIDX_W-1:0]   read_index;
  logic        [phr_pkg::POS_W-1:0]    tolerance;

  modport source (output valid, command, channel, peak_level, position, read_index,
                  tolerance, input ready);
  modport sink (input valid, command, channel, peak_level, position, read_index,
                tolerance, output ready);
  modport monitor (input valid, ready, command, channel, peak_level, position,
                   read_index, tolerance);
endinterface

interface phr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [phr_pkg::PEAK_W-1:0]   peak_out;
  logic signed [phr_pkg::NIDX_W-1:0]   nearest_index;

  modport source (output valid, peak_out, nearest_index, input ready);
  modport sink (input valid, peak_out, nearest_index, output ready);
  modport monitor (input valid, ready, peak_out, nearest_index);
endinterface

/* sv/peak_history_ring_with_nearest_search.sv */
// ----------------------------------------------------------------------------
// peak_history_ring_with_nearest_search
// Per-channel peak rings with a shared position store and nearest search.
// ----------------------------------------------------------------------------
// One command word is handled at a time; its result word goes to an output
// register, so the next command is taken while that result waits. A record
// writes both memories, a read does one registered read of the peak memory,
// a nearest search reads the position memory one entry per cycle over
// history_length entries, and a channel reset clears its peak memory row one
// entry per cycle. After reset the block clears both memories before it takes
// a command; a history_length write while idle starts a sweep of the position
// memory.
// ----------------------------------------------------------------------------
module peak_history_ring_with_nearest_search #(
  parameter int DEPTH    = 256,
  parameter int CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  phr_in_if.sink                        item,
  phr_out_if.source                     result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [phr_pkg::APB_AW-1:0]    paddr,
  input  logic [phr_pkg::APB_DW-1:0]    pwdata,
  output logic [phr_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import phr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam int PW = CW + AW;

  logic              cfg_wr;
  logic [LW-1:0]     cfg_len;
  logic              pos_we;
  logic              pos_re;
  logic [AW-1:0]     pos_addr;
  logic [SPOS_W-1:0] pos_wdata;
  logic [SPOS_W-1:0] pos_rdata;
  logic              peak_we;
  logic              peak_re;
  logic [PW-1:0]     peak_addr;
  logic [PEAK_W-1:0] peak_wdata;
  logic [PEAK_W-1:0] peak_rdata;
  srch_ctl_t         sctl;
  srch_sts_t         ssts;
  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  tolerance;
  logic              res_valid;
  logic              res_take;
  logic [PEAK_W-1:0] res_peak;
  logic [NIDX_W-1:0] res_idx;
  logic              out_valid;

  // register port, history_length at byte address 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : APB_DW'(cfg_len);

  phr_ctrl #(
    .DEPTH    (DEPTH),
    .CHANNELS (CHANNELS),
    .AW       (AW),
    .CW       (CW),
    .LW       (LW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cfg_wr     (cfg_wr),
    .cfg_data   (pwdata[CFG_W-1:0]),
    .cfg_len    (cfg_len),
    .pos_we     (pos_we),
    .pos_re     (pos_re),
    .pos_addr   (pos_addr),
    .pos_wdata  (pos_wdata),
    .peak_we    (peak_we),
    .peak_re    (peak_re),
    .peak_addr  (peak_addr),
    .peak_wdata (peak_wdata),
    .peak_rdata (peak_rdata),
    .sctl       (sctl),
    .ssts       (ssts),
    .position   (position),
    .tolerance  (tolerance),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res_peak   (res_peak),
    .res_idx    (res_idx)
  );

  // shared position store
  phr_ram #(
    .WIDTH (SPOS_W),
    .AW    (AW)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .re    (pos_re),
    .addr  (pos_addr),
    .wdata (pos_wdata),
    .rdata (pos_rdata)
  );

  // per-channel peak rings, row per channel
  phr_ram #(
    .WIDTH (PEAK_W),
    .AW    (PW)
  ) u_peak_ram (
    .clk   (clk),
    .we    (peak_we),
    .re    (peak_re),
    .addr  (peak_addr),
    .wdata (peak_wdata),
    .rdata (peak_rdata)
  );

  phr_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .ctl       (sctl),
    .stored    (pos_rdata),
    .position  (position),
    .tolerance (tolerance),
    .sts       (ssts)
  );

  // output register
  assign res_take = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      result.peak_out      <= res_peak;
      result.nearest_index <= res_idx;
    end
  end

  assign result.valid = out_valid;

endmodule

/* sv/phr_ram.sv */
// ----------------------------------------------------------------------------
// phr_ram
// Single-port synchronous memory, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module phr_ram #(
  parameter int WIDTH = 32,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* sv/phr_dist.sv */
// ----------------------------------------------------------------------------
// phr_dist
// Search datapath: absolute distance stage, then best-so-far compare stage.
// ----------------------------------------------------------------------------
module phr_dist (
  input  logic                          clk,
  input  logic                          rst,
  input  phr_pkg::srch_ctl_t            ctl,
  input  logic [phr_pkg::SPOS_W-1:0]    stored,
  input  logic [phr_pkg::POS_W-1:0]     position,
  input  logic [phr_pkg::POS_W-1:0]     tolerance,
  output phr_pkg::srch_sts_t            sts
);
  import phr_pkg::*;

  logic [SPOS_W:0]   sx;
  logic [SPOS_W:0]   px;
  logic [SPOS_W:0]   diff_sp;
  logic [SPOS_W:0]   diff_ps;
  logic [SPOS_W-1:0] gap_next;
  logic [SPOS_W-1:0] gap;
  logic              v2;
  logic [NIDX_W-1:0] idx2;
  logic [SPOS_W-1:0] best;
  logic [NIDX_W-1:0] best_idx;

  // both differences in parallel, pick the non-negative one
  always_comb begin
    sx       = {stored[SPOS_W-1], stored};
    px       = {2'b00, position};
    diff_sp  = sx - px;
    diff_ps  = px - sx;
    gap_next = diff_sp[SPOS_W] ? diff_ps[SPOS_W-1:0] : diff_sp[SPOS_W-1:0];
  end

  // distance stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= ctl.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sample) begin
      gap  <= gap_next;
      idx2 <= ctl.idx;
    end
  end

  // compare stage, strict less keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      best     <= {1'b0, tolerance};
      best_idx <= NONE_IDX;
    end else if (v2 && (gap < best)) begin
      best     <= gap;
      best_idx <= idx2;
    end
  end

  assign sts.busy     = v2;
  assign sts.best_idx = best_idx;

endmodule

/* sv/phr_ctrl.sv */
// ----------------------------------------------------------------------------
// phr_ctrl
// Command sequencer: clear sweeps, ring pointers, memory accesses, search walk.
// ----------------------------------------------------------------------------
module phr_ctrl #(
  parameter int DEPTH    = 256,
  parameter int CHANNELS = 8,
  parameter int AW       = 8,
  parameter int CW       = 3,
  parameter int LW       = 9
) (
  input  logic                           clk,
  input  logic                           rst,
  phr_in_if.sink                         item,
  input  logic                           cfg_wr,
  input  logic [phr_pkg::CFG_W-1:0]      cfg_data,
  output logic [LW-1:0]                  cfg_len,
  // position store
  output logic                           pos_we,
  output logic                           pos_re,
  output logic [AW-1:0]                  pos_addr,
  output logic [phr_pkg::SPOS_W-1:0]     pos_wdata,
  // peak store
  output logic                           peak_we,
  output logic                           peak_re,
  output logic [CW+AW-1:0]               peak_addr,
  output logic [phr_pkg::PEAK_W-1:0]     peak_wdata,
  input  logic [phr_pkg::PEAK_W-1:0]     peak_rdata,
  // search unit
  output phr_pkg::srch_ctl_t             sctl,
  input  phr_pkg::srch_sts_t             ssts,
  output logic [phr_pkg::POS_W-1:0]      position,
  output logic [phr_pkg::POS_W-1:0]      tolerance,
  // result handoff
  output logic                           res_valid,
  input  logic                           res_take,
  output logic [phr_pkg::PEAK_W-1:0]     res_peak,
  output logic [phr_pkg::NIDX_W-1:0]     res_idx
);
  import phr_pkg::*;

  localparam int PW = CW + AW;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_RWAIT  = 3'd3;
  localparam logic [2:0] S_SEARCH = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]        state;
  logic [PW-1:0]     cnt;
  logic              sw_all;
  logic              sw_peak;
  logic              sw_pos;
  logic              sw_cmd;
  logic              sweep_end;

  logic [CMD_W-1:0]  cmd;
  logic [CW-1:0]     ch_idx;
  logic              ch_ok;
  logic              ch_zero;
  logic [PEAK_W-1:0] peak_lv;
  logic [AW-1:0]     ridx;
  logic              rd_ok;

  logic [AW-1:0]     wp [2**CW];
  logic [AW-1:0]     wp_cur;
  logic [AW-1:0]     wp_eff;
  logic [AW-1:0]     wp_next;
  logic [LW:0]       wp_inc;

  logic [LW-1:0]     len;
  logic [LW-1:0]     len_next;
  logic [LW+CFG_W-1:0] cfg_ext;

  logic [LW-1:0]     si;
  logic              issue;
  logic              v1;
  logic [NIDX_W-1:0] idx1;
  logic [LW+NIDX_W-1:0] si_ext;

  logic              accept;
  logic [CW+CH_W-1:0]  ch_ext;
  logic [LW+7:0]     ri_ext;
  logic              ch_ok_in;
  logic              rd_ok_in;

  assign accept     = item.valid && item.ready;
  assign item.ready = (state == S_IDLE) && !cfg_wr;
  assign cfg_len    = len;

  // input decode at acceptance
  always_comb begin
    ch_ext   = {{CW{1'b0}}, item.channel};
    ri_ext   = {{LW{1'b0}}, item.read_index[7:0]};
    ch_ok_in = ch_ext < (CW+CH_W)'(CHANNELS);
    rd_ok_in = ch_ok_in && !item.read_index[RIDX_W-1] && (ri_ext < {8'b0, len});
  end

  // clamp written length to 1..DEPTH
  always_comb begin
    cfg_ext = {{LW{1'b0}}, cfg_data};
    if (cfg_ext == '0) begin
      len_next = LW'(1);
    end else if (cfg_ext > (LW+CFG_W)'(DEPTH)) begin
      len_next = LW'(DEPTH);
    end else begin
      len_next = cfg_ext[LW-1:0];
    end
  end

  // ring pointer for a record, wrapped at the current length
  always_comb begin
    wp_cur  = wp[ch_idx];
    wp_eff  = (LW'(wp_cur) >= len) ? '0 : wp_cur;
    wp_inc  = {1'b0, LW'(wp_eff)} + (LW+1)'(1);
    wp_next = (wp_inc >= {1'b0, len}) ? '0 : wp_inc[AW-1:0];
  end

  // sweep end: whole peak store on power-up, one ring row otherwise
  assign sweep_end = sw_all ? (&cnt) : (&cnt[AW-1:0]);

  // search walk
  assign issue  = (state == S_SEARCH) && (si < len);
  assign si_ext = {{NIDX_W{1'b0}}, si};

  // memory access decode
  always_comb begin
    pos_we     = 1'b0;
    pos_re     = 1'b0;
    pos_addr   = '0;
    pos_wdata  = '1;
    peak_we    = 1'b0;
    peak_re    = 1'b0;
    peak_addr  = {ch_idx, wp_eff};
    peak_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        pos_addr = cnt[AW-1:0];
        pos_we   = sw_pos && (!sw_all || (cnt[PW-1:AW] == '0));
        peak_we  = sw_peak;
        peak_addr = sw_all ? cnt : {ch_idx, cnt[AW-1:0]};
      end
      S_EXEC: begin
        if (cmd == CMD_RECORD) begin
          pos_we     = ch_ok;
          pos_addr   = wp_eff;
          pos_wdata  = {1'b0, position};
          peak_we    = ch_ok;
          peak_addr  = {ch_idx, wp_eff};
          peak_wdata = peak_lv;
        end else if (cmd == CMD_READ) begin
          peak_re   = rd_ok;
          peak_addr = {ch_idx, ridx};
        end
      end
      S_SEARCH: begin
        pos_re   = issue;
        pos_addr = si[AW-1:0];
      end
      S_IDLE, S_RWAIT, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign sctl.start  = (state == S_EXEC) && (cmd == CMD_SEARCH);
  assign sctl.sample = v1;
  assign sctl.idx    = idx1;
  assign res_valid   = (state == S_DONE);

  // payload latches
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd       <= item.command;
      ch_idx    <= ch_ext[CW-1:0];
      ch_ok     <= ch_ok_in;
      ch_zero   <= (item.channel == '0);
      peak_lv   <= item.peak_level;
      position  <= item.position;
      tolerance <= item.tolerance;
      ridx      <= ri_ext[AW-1:0];
      rd_ok     <= rd_ok_in;
    end
  end

  // search issue pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      idx1 <= si_ext[NIDX_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      sw_all  <= 1'b1;
      sw_peak <= 1'b1;
      sw_pos  <= 1'b1;
      sw_cmd  <= 1'b0;
      len     <= LW'(DEPTH);
      si      <= '0;
      for (int i = 0; i < 2**CW; i++) begin
        wp[i] <= '0;
      end
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (sweep_end) begin
            cnt   <= '0;
            state <= sw_cmd ? S_DONE : S_IDLE;
          end else begin
            cnt <= cnt + PW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            state    <= S_EXEC;
            res_peak <= '0;
            res_idx  <= NONE_IDX;
          end
        end
        S_EXEC: begin
          unique case (cmd)
            CMD_RESET: begin
              if (ch_ok) begin
                wp[ch_idx] <= '0;
                sw_all     <= 1'b0;
                sw_peak    <= 1'b1;
                sw_pos     <= ch_zero;
                sw_cmd     <= 1'b1;
                cnt        <= '0;
                state      <= S_CLEAR;
              end else begin
                state <= S_DONE;
              end
            end
            CMD_RECORD: begin
              if (ch_ok) begin
                wp[ch_idx] <= wp_next;
              end
              state <= S_DONE;
            end
            CMD_READ: begin
              state <= S_RWAIT;
            end
            CMD_SEARCH: begin
              si    <= '0;
              state <= S_SEARCH;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_RWAIT: begin
          if (rd_ok) begin
            res_peak <= peak_rdata;
          end
          state <= S_DONE;
        end
        S_SEARCH: begin
          if (issue) begin
            si <= si + LW'(1);
          end else if (!v1 && !ssts.busy) begin
            res_idx <= ssts.best_idx;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // length write: pointers to zero, positions swept back to empty when idle
      if (cfg_wr) begin
        len <= len_next;
        for (int i = 0; i < 2**CW; i++) begin
          wp[i] <= '0;
        end
        if (state == S_IDLE) begin
          state   <= S_CLEAR;
          cnt     <= '0;
          sw_all  <= 1'b0;
          sw_peak <= 1'b0;
          sw_pos  <= 1'b1;
          sw_cmd  <= 1'b0;
        end
      end
    end
  end

endmodule

/* sv/phr_check.sv */
// ----------------------------------------------------------------------------
// phr_check
// Port-level checks of the peak history block, bound to the top level.
// ----------------------------------------------------------------------------
module phr_check (
  input logic          clk,
  input logic          rst,
  phr_in_if.sink       item,
  phr_out_if.source    result
);
  import phr_pkg::*;

  logic [CMD_W-1:0] cmd_q [2];
  logic [1:0]       n_q;
  logic [CMD_W-1:0] head_cmd;
  logic             item_acc;
  logic             res_acc;

  assign item_acc = item.valid && item.ready;
  assign res_acc  = result.valid && result.ready;
  assign head_cmd = cmd_q[0];

  // commands of the words whose results are still owed, oldest first
  always_ff @(posedge clk) begin
    if (rst) begin
      n_q <= '0;
    end else begin
      case ({item_acc, res_acc})
        2'b10: begin
          cmd_q[n_q[0]] <= item.command;
          n_q           <= n_q + 2'd1;
        end
        2'b01: begin
          cmd_q[0] <= cmd_q[1];
          n_q      <= n_q - 2'd1;
        end
        2'b11: begin
          if (n_q == 2'd1) begin
            cmd_q[0] <= item.command;
          end else begin
            cmd_q[0] <= cmd_q[1];
            cmd_q[1] <= item.command;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // a stalled result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid)
    else $error("result dropped while stalled");

  // one word at a time
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    item_acc |=> !item.ready)
    else $error("command taken while busy");

  // only a search reports an index
  a_idx_none: assert property (@(posedge clk) disable iff (rst)
    res_acc && (head_cmd != CMD_SEARCH) |-> result.nearest_index == NONE_IDX)
    else $error("index reported for non-search command");

  // only a read reports a peak
  a_peak_zero: assert property (@(posedge clk) disable iff (rst)
    res_acc && (head_cmd != CMD_READ) |-> result.peak_out == '0)
    else $error("peak reported for non-read command");

  // memory clear pass follows reset
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !result.valid && !item.ready)
    else $error("block active right after reset");

endmodule

bind peak_history_ring_with_nearest_search phr_check u_check (
  .clk    (clk),
  .rst    (rst),
  .item   (item),
  .result (result)
);

/* dv/tb_peak_history_ring_with_nearest_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_peak_history_ring_with_nearest_search
// Self-checking bench for the peak history rings and nearest-position search.
// Command words go in through a valid/ready channel with random gaps. A local
// copy of the position store, the per-channel peak rings and the write
// pointers predicts each result word, and a scoreboard compares it in order.
// The ring length register is rewritten between phases over its whole range.
// ----------------------------------------------------------------------------
module tb_peak_history_ring_with_nearest_search;
  import phr_pkg::*;

  localparam int RING_DEPTH  = 256;
  localparam int NUM_CH      = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 20000;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_WORDS = 110;

  localparam logic [APB_AW-1:0] LEN_ADDR   = 3'd0;
  localparam logic [APB_AW-1:0] UNUSED_ADDR = 3'd4;
  localparam logic [POS_W-1:0]  POS_MAX    = '1;

  typedef struct packed {
    logic        [CMD_W-1:0]  command;
    logic        [CH_W-1:0]   channel;
    logic signed [PEAK_W-1:0] peak_level;
    logic        [POS_W-1:0]  position;
    logic signed [RIDX_W-1:0] read_index;
    logic        [POS_W-1:0]  tolerance;
  } cmd_word_t;

  typedef struct packed {
    logic signed [PEAK_W-1:0] peak_out;
    logic signed [NIDX_W-1:0] nearest_index;
  } res_word_t;

  // --------------------------------------------------------------------------
  // predictor of the ring state plus the queue of expected result words
  // --------------------------------------------------------------------------
  class peak_history_scoreboard;
    logic signed [SPOS_W-1:0] pos_hist[RING_DEPTH];
    logic        [PEAK_W-1:0] peak_hist[NUM_CH][RING_DEPTH];
    int unsigned              wr_ptr[NUM_CH];
    int unsigned              hist_len;
    res_word_t                pending[$];
    int                       errors;

    function new();
      errors = 0;
      for (int c = 0; c < NUM_CH; c++) begin
        for (int i = 0; i < RING_DEPTH; i++) peak_hist[c][i] = '0;
      end
      set_length(RING_DEPTH);
    endfunction

    function void clear_positions();
      for (int i = 0; i < RING_DEPTH; i++) pos_hist[i] = '1;
    endfunction

    // zero counts as one, anything past the store counts as the store size
    function void set_length(int unsigned v);
      hist_len = (v == 0) ? 1 : (v > RING_DEPTH) ? RING_DEPTH : v;
      clear_positions();
      for (int c = 0; c < NUM_CH; c++) wr_ptr[c] = 0;
    endfunction

    function void note_command(cmd_word_t w);
      res_word_t      r;
      int unsigned    p;
      longint         s;
      longint         q;
      logic [63:0]    gap;
      logic [63:0]    best;
      r.peak_out      = '0;
      r.nearest_index = NONE_IDX;
      case (w.command)
        CMD_RESET: begin
          if (w.channel < NUM_CH) begin
            if (w.channel == 0) clear_positions();
            wr_ptr[w.channel] = 0;
            for (int i = 0; i < RING_DEPTH; i++) peak_hist[w.channel][i] = '0;
          end
        end
        CMD_RECORD: begin
          if (w.channel < NUM_CH) begin
            p = wr_ptr[w.channel];
            if (p >= hist_len) p = 0;
            pos_hist[p] = {1'b0, w.position};
            peak_hist[w.channel][p] = w.peak_level;
            p++;
            if (p >= hist_len) p = 0;
            wr_ptr[w.channel] = p;
          end
        end
        CMD_READ: begin
          // negative index or one at or past the ring length reads zero
          if (w.channel < NUM_CH && !w.read_index[RIDX_W-1] &&
              int'(w.read_index) < hist_len)
            r.peak_out = peak_hist[w.channel][w.read_index[RIDX_W-2:0]];
        end
        default: begin
          // first entry with the smallest distance strictly under tolerance
          best = {2'b00, w.tolerance};
          q    = longint'({2'b00, w.position});
          for (int i = 0; i < hist_len; i++) begin
            s   = longint'(pos_hist[i]);
            gap = (s >= q) ? 64'(s - q) : 64'(q - s);
            if (gap < best) begin
              best            = gap;
              r.nearest_index = NIDX_W'(i);
            end
          end
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(res_word_t got);
      res_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word: peak %h index %h",
                 $time, got.peak_out, got.nearest_index);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.peak_out !== want.peak_out) begin
        $display("%0t: peak_out expected %h actual %h",
                 $time, want.peak_out, got.peak_out);
        errors++;
      end
      if (got.nearest_index !== want.nearest_index) begin
        $display("%0t: nearest_index expected %h actual %h",
                 $time, want.nearest_index, got.nearest_index);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  phr_in_if  in_ch ();
  phr_out_if out_ch ();

  peak_history_scoreboard sb;

  bit                  quiet_tail;
  bit                  hold_off_req;
  logic [POS_W-1:0]    pos_base;
  int                  idle_cycles;

  peak_history_ring_with_nearest_search #(
    .DEPTH    (RING_DEPTH),
    .CHANNELS (NUM_CH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .item    (in_ch),
    .result  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // accepted command words feed the predictor
  always @(posedge clk) begin
    if (rst === 1'b0 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
      sb.note_command('{in_ch.command, in_ch.channel, in_ch.peak_level,
                        in_ch.position, in_ch.read_index, in_ch.tolerance});
  end

  // accepted result words are checked in order
  always @(posedge clk) begin
    if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result('{out_ch.peak_out, out_ch.nearest_index});
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side ready, with random stalls and one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  function automatic logic [POS_W-1:0] rand_pos62();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[POS_W-1:0];
  endfunction

  // offer one command word, with an occasional gap before it
  task automatic send_word(input cmd_word_t w);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= w.command;
    in_ch.channel    <= w.channel;
    in_ch.peak_level <= w.peak_level;
    in_ch.position   <= w.position;
    in_ch.read_index <= w.read_index;
    in_ch.tolerance  <= w.tolerance;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic issue(input logic [CMD_W-1:0] cmd, input int ch,
                       input logic [PEAK_W-1:0] peak, input logic [POS_W-1:0] pos,
                       input int ridx, input logic [POS_W-1:0] tol);
    cmd_word_t w;
    w.command    = cmd;
    w.channel    = CH_W'(ch);
    w.peak_level = peak;
    w.position   = pos;
    w.read_index = RIDX_W'(ridx);
    w.tolerance  = tol;
    send_word(w);
  endtask

  // sender pause until every result word is back
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // apb write: setup then access, done when pready is seen
  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == LEN_ADDR) sb.set_length(32'(data[CFG_W-1:0]));
  endtask

  task automatic set_ring_length(input int unsigned len);
    wait_results_done();
    write_reg(LEN_ADDR, APB_DW'(len));
  endtask

  // random command word: clustered positions so searches find neighbors
  function automatic cmd_word_t random_word();
    cmd_word_t w;
    int        sel;
    int        hi;
    sel = $urandom_range(0, 99);
    if (sel < 40)      w.command = CMD_RECORD;
    else if (sel < 65) w.command = CMD_READ;
    else if (sel < 92) w.command = CMD_SEARCH;
    else               w.command = CMD_RESET;
    w.channel    = CH_W'($urandom_range(0, NUM_CH - 1));
    w.peak_level = $urandom;
    if ($urandom_range(0, 9) < 8) w.position = pos_base + POS_W'($urandom_range(0, 63));
    else                          w.position = rand_pos62();
    sel = $urandom_range(0, 3);
    case (sel)
      0:       w.tolerance = POS_W'($urandom_range(0, 3));
      1:       w.tolerance = POS_W'($urandom_range(0, 100));
      2:       w.tolerance = rand_pos62();
      default: w.tolerance = POS_MAX;
    endcase
    sel = $urandom_range(0, 99);
    hi  = (sb.hist_len + 2 > 255) ? 255 : sb.hist_len + 2;
    if (sel < 60)      w.read_index = RIDX_W'($urandom_range(0, hi));
    else if (sel < 75) w.read_index = RIDX_W'(-int'($urandom_range(1, 256)));
    else               w.read_index = RIDX_W'($urandom);
    return w;
  endfunction

  // main sequence
  initial begin
    int unsigned lengths[NUM_PHASES];
    int          sel;
    lengths = '{256, 3, 0, 17, 300, 64, 2, 511, 200, 256};
    sb           = new();
    quiet_tail   = 1'b0;
    hold_off_req = 1'b0;
    idle_cycles  = 0;
    pos_base     = '0;
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_RESET;
    in_ch.channel    <= '0;
    in_ch.peak_level <= '0;
    in_ch.position   <= '0;
    in_ch.read_index <= '0;
    in_ch.tolerance  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store: zero tolerance, unset entries at distance one, far miss
    issue(CMD_SEARCH, 0, 32'h0, '0, 0, '0);
    issue(CMD_SEARCH, 1, 32'h0, '0, 0, 62'd2);
    issue(CMD_SEARCH, 2, 32'h0, POS_MAX, 0, POS_MAX);
    // peak extremes on several channels, shared position slots
    issue(CMD_RECORD, 0, 32'h7fff_ffff, POS_MAX, 0, '0);
    issue(CMD_RECORD, 7, 32'h8000_0000, '0, 0, '0);
    issue(CMD_RECORD, 3, 32'hffff_ffff, 62'd1000, 0, '0);
    issue(CMD_RECORD, 3, 32'h0001_0000, 62'd1000, 0, '0);
    // tie keeps the lowest index
    issue(CMD_SEARCH, 4, 32'h0, 62'd1000, 0, 62'd1);
    issue(CMD_SEARCH, 5, 32'h0, POS_MAX, 0, POS_MAX);
    issue(CMD_READ, 0, 32'h0, '0, 0, '0);
    issue(CMD_READ, 7, 32'h0, '0, 0, '0);
    issue(CMD_READ, 3, 32'h0, '0, 1, '0);
    // negative and last in-range indexes
    issue(CMD_READ, 3, 32'h0, '0, -1, '0);
    issue(CMD_READ, 3, 32'h0, '0, 255, '0);
    issue(CMD_READ, 3, 32'h0, '0, -256, '0);
    // channel reset, then the channel 0 reset that also clears positions
    issue(CMD_RESET, 3, 32'h0, '0, 0, '0);
    issue(CMD_READ, 3, 32'h0, '0, 0, '0);
    issue(CMD_RESET, 0, 32'h0, '0, 0, '0);
    issue(CMD_SEARCH, 6, 32'h0, 62'd1000, 0, POS_MAX);

    // single-entry ring: wrap on every record, index one is out of range
    set_ring_length(1);
    issue(CMD_RECORD, 1, 32'h0000_0001, 62'd5, 0, '0);
    issue(CMD_RECORD, 1, 32'h0000_0002, 62'd6, 0, '0);
    issue(CMD_READ, 1, 32'h0, '0, 0, '0);
    issue(CMD_READ, 1, 32'h0, '0, 1, '0);
    issue(CMD_SEARCH, 1, 32'h0, 62'd6, 0, 62'd1);
    // write to an address with no register leaves the state alone
    wait_results_done();
    write_reg(UNUSED_ADDR, 32'h0000_0005);
    issue(CMD_SEARCH, 1, 32'h0, 62'd6, 0, 62'd1);

    // random phases over several ring lengths
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_ring_length(lengths[ph]);
      if (ph == NUM_PHASES - 1) quiet_tail = 1'b1;
      sel = $urandom_range(0, 2);
      if (sel == 0)      pos_base = '0;
      else if (sel == 1) pos_base = POS_MAX - 62'd63;
      else               pos_base = rand_pos62();
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 1 && n == 20) hold_off_req = 1'b1;
        if (ph == 2 && n == 50) wait_results_done();
        send_word(random_word());
      end
    end

    wait_results_done();
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
sv/phr_pkg.sv
sv/phr_if.sv
sv/phr_ram.sv
sv/phr_dist.sv
sv/phr_ctrl.sv
sv/peak_history_ring_with_nearest_search.sv
sv/phr_check.sv
dv/tb_peak_history_ring_with_nearest_search.sv
